@@ hdl/assert_macros.svh @@
// Assertion helper macros shared by the RTL of this block.
// No dependencies; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RWMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define RWMC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define RWMC_ASSERT(lbl, prop)
`define RWMC_NEVER(lbl, expr)
`endif
`endif

@@ hdl/rwmc_pkg.sv @@
// Shared constants and types of the reuse window miss counter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rwmc_pkg;

  localparam int unsigned AddrW        = 32;  // block_addr field width
  localparam int unsigned WinLenW      = 7;   // window_len register width
  localparam int unsigned CountW       = 32;  // miss_count field width
  localparam int unsigned DefWindowDepth = 64;
  localparam int unsigned DefAddrBits  = 32;
  localparam int unsigned GroupSize    = 8;   // match bits per first-level OR

  localparam logic [WinLenW-1:0] WinLenReset = 7'd64;
  localparam logic [CountW-1:0]  CountMax    = {CountW{1'b1}};

  // per-cycle commands from the sequencer to every history cell
  typedef struct packed {
    logic cmp;    // register a compare against the probe
    logic shift;  // take the neighbor's entry
    logic clear;  // drop the valid bit while shifting (end of trace)
  } cell_ctrl_t;

endpackage

@@ hdl/reuse_window_miss_counter_top.sv @@
// Top level of the reuse window miss counter: sequencer, cell chain, count.
// Depends on rwmc_pkg, rwmc_cell, rwmc_hit_reduce and assert_macros.svh.
//
// Usage:
//  Slave stream carries one trace access per transfer: tdata = block_addr,
//  tlast = end of trace. Master stream returns one result per access:
//  tdata = running miss count, tuser = miss flag, tlast = echo of the
//  input tlast (the count is final for the trace).
//  cfg_we_i/cfg_wdata_i load window_len (reset 64); write only while idle.
// Operation:
//  When an access is accepted every cell compares it with its entry and
//  registers a match flag. In the group step the first-level OR of groups
//  of eight flags is registered; the finish step closes the OR, updates the
//  count, shifts the access into the chain and loads the output register.
//  A new access is taken only once the last one is through its finish step,
//  and the finish step waits while the output register is not free.
// Reset: all valid bits and the count clear at once, no clearing pass.
// Stall: a waiting result is held in the output register; the next access
//  is still taken and compared, and its finish step waits for a free slot.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module reuse_window_miss_counter_top #(
  parameter int unsigned WINDOW_DEPTH = rwmc_pkg::DefWindowDepth,
  parameter int unsigned ADDR_BITS    = rwmc_pkg::DefAddrBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [rwmc_pkg::WinLenW-1:0] cfg_wdata_i,     // window_len
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rwmc_pkg::AddrW-1:0]   s_axis_tdata_i,  // [31:0] block_addr
  input  logic                         s_axis_tlast_i,  // last_item
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [rwmc_pkg::CountW-1:0]  m_axis_tdata_o,  // [31:0] miss_count
  output logic                         m_axis_tuser_o,  // [0] is_miss
  output logic                         m_axis_tlast_o   // trace_done
);

  // only the low bits of the block number take part in the compare
  localparam int unsigned CmpBits =
    (ADDR_BITS < rwmc_pkg::AddrW) ? ADDR_BITS : rwmc_pkg::AddrW;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StGroup  = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0] state_q, state_d;

  logic [rwmc_pkg::WinLenW-1:0] win_len_q;
  logic [CmpBits-1:0]           hold_blk_q;
  logic                         hold_last_q;
  logic [rwmc_pkg::CountW-1:0]  miss_total_q;
  logic [rwmc_pkg::CountW-1:0]  miss_next;

  logic                         m_valid_q;
  logic [rwmc_pkg::CountW-1:0]  m_count_q;
  logic                         m_miss_q;
  logic                         m_last_q;

  logic in_fire, out_free, fin_fire, hit;

  rwmc_pkg::cell_ctrl_t cell_ctrl;
  logic [CmpBits-1:0]   cell_blk [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] cell_vld;
  logic [WINDOW_DEPTH-1:0] cell_en;
  logic [WINDOW_DEPTH-1:0] cell_match;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~m_valid_q | m_axis_tready_i;
  assign fin_fire = (state_q == StFinish) & out_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_fire)  state_d = StGroup;
      StGroup:                state_d = StFinish;
      StFinish: if (out_free) state_d = StIdle;
      default:                state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      win_len_q <= rwmc_pkg::WinLenReset;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        win_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hold_blk_q  <= s_axis_tdata_i[CmpBits-1:0];
      hold_last_q <= s_axis_tlast_i;
    end
  end

  // cell chain, entry 0 newest
  assign cell_ctrl.cmp   = in_fire;
  assign cell_ctrl.shift = fin_fire;
  assign cell_ctrl.clear = hold_last_q;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic [CmpBits-1:0] nb_blk;
    logic               nb_vld;

    if (k == 0) begin : g_head
      assign nb_blk = hold_blk_q;
      assign nb_vld = 1'b1;
    end else begin : g_body
      assign nb_blk = cell_blk[k-1];
      assign nb_vld = cell_vld[k-1];
    end

    // a window beyond the chain length simply enables every cell
    assign cell_en[k] = (32'(win_len_q) > 32'(k));

    rwmc_cell #(
      .AddrBits(CmpBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .en_i    (cell_en[k]),
      .probe_i (s_axis_tdata_i[CmpBits-1:0]),
      .blk_i   (nb_blk),
      .valid_i (nb_vld),
      .blk_o   (cell_blk[k]),
      .valid_o (cell_vld[k]),
      .match_o (cell_match[k])
    );
  end

  rwmc_hit_reduce #(
    .Depth(WINDOW_DEPTH)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (state_q == StGroup),
    .match_i (cell_match),
    .hit_o   (hit)
  );

  // saturating miss count
  assign miss_next = (!hit && miss_total_q != rwmc_pkg::CountMax)
                   ? miss_total_q + {{(rwmc_pkg::CountW-1){1'b0}}, 1'b1}
                   : miss_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_total_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (fin_fire) begin
        miss_total_q <= hold_last_q ? '0 : miss_next;
        m_valid_q    <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      m_count_q <= miss_next;
      m_miss_q  <= ~hit;
      m_last_q  <= hold_last_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_count_q;
  assign m_axis_tuser_o  = m_miss_q;
  assign m_axis_tlast_o  = m_last_q;

  // checks
  `RWMC_ASSERT(a_result_from_finish,
    $rose(m_axis_tvalid_o) |-> $past(state_q == StFinish))
  `RWMC_ASSERT(a_count_clears_after_last,
    (fin_fire && hold_last_q) |=> (miss_total_q == '0))
  `RWMC_ASSERT(a_count_saturates,
    (miss_total_q == rwmc_pkg::CountMax && !fin_fire) |=>
      (miss_total_q == rwmc_pkg::CountMax))
  `RWMC_ASSERT(a_flag_matches_hit,
    fin_fire |=> (m_axis_tuser_o == !$past(hit)))
  `RWMC_NEVER(a_no_accept_while_busy,
    in_fire && (state_q == StGroup || state_q == StFinish))

endmodule

@@ hdl/rwmc_cell.sv @@
// One history entry of the reuse window: stored block, valid bit, match flag.
// Depends on rwmc_pkg for the control struct.
`timescale 1ns / 1ps

module rwmc_cell #(
  parameter int unsigned AddrBits = rwmc_pkg::DefAddrBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rwmc_pkg::cell_ctrl_t ctrl_i,
  input  logic                 en_i,     // entry lies inside the window
  input  logic [AddrBits-1:0]  probe_i,
  input  logic [AddrBits-1:0]  blk_i,    // from the newer neighbor
  input  logic                 valid_i,
  output logic [AddrBits-1:0]  blk_o,
  output logic                 valid_o,
  output logic                 match_o
);

  logic [AddrBits-1:0] blk_q;
  logic                valid_q;
  logic                match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      blk_q <= blk_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctrl_i.shift) begin
        valid_q <= valid_i & ~ctrl_i.clear;
      end
      if (ctrl_i.cmp) begin
        match_q <= en_i & valid_q & (blk_q == probe_i);
      end
    end
  end

  assign blk_o   = blk_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

@@ hdl/rwmc_hit_reduce.sv @@
// OR tree over the match flags of all history cells; the first level is registered.
// Depends on rwmc_pkg for the group size.
`timescale 1ns / 1ps

module rwmc_hit_reduce #(
  parameter int unsigned Depth = rwmc_pkg::DefWindowDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [Depth-1:0] match_i,
  output logic             hit_o
);

  localparam int unsigned Gs   = rwmc_pkg::GroupSize;
  localparam int unsigned NGrp = (Depth + Gs - 1) / Gs;

  logic [NGrp-1:0][Gs-1:0] bits;
  logic [NGrp-1:0]         grp_q;

  for (genvar g = 0; g < NGrp; g++) begin : g_grp
    for (genvar j = 0; j < Gs; j++) begin : g_bit
      if (g * Gs + j < Depth) begin : g_on
        assign bits[g][j] = match_i[g * Gs + j];
      end else begin : g_pad
        assign bits[g][j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else if (load_i) begin
      for (int g = 0; g < NGrp; g++) begin
        grp_q[g] <= |bits[g];
      end
    end
  end

  assign hit_o = |grp_q;

endmodule
